[sv/fqs_pkg.sv]
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared sizes, operation and status codes, and a slot helper for the
// bounded FIFO queue with search.
// ----------------------------------------------------------------------------
package fqs_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Capacity register
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int LIM_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  // Field widths
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Advance a slot index around the circular store
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
    logic [IDX_W-1:0] inc;
    inc = slot + 1'b1;
    return (slot == IDX_W'(DEPTH - 1)) ? '0 : inc;
  endfunction

endpackage

[sv/fifo_queue_with_search_top.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search_top
// Bounded circular FIFO of signed values with push, pop and linear search.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Push and pop are first accepted (which
// starts the read of the head slot), then update the single-port-read store
// and load the result register. Search reads the held entries from oldest to
// newest, one per cycle through the RAM read port, and stops at the first
// match or at the newest entry. An empty queue answers pop or search with
// empty status. A result waits in its output register while the next request
// is accepted; a request finishes only once the output register is free.
// Capacity values above the store depth act as the depth; zero makes every
// push report full.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_top (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                cfg_write_en,
  input  logic [fqs_pkg::CAP_W-1:0]           cfg_write_data,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fqs_pkg::OP_W-1:0]            opcode,
  input  logic signed [fqs_pkg::DATA_WIDTH-1:0] value,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fqs_pkg::STAT_W-1:0]          status,
  output logic signed [fqs_pkg::DATA_WIDTH-1:0] popped_value,
  output logic                                found_flag
);

  import fqs_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state;
  logic [CAP_W-1:0]        capacity;
  logic [IDX_W-1:0]        head_index;
  logic [IDX_W-1:0]        tail_index;
  logic [CNT_W-1:0]        entry_count;
  logic [OP_W-1:0]         cmd_op;
  logic signed [DATA_WIDTH-1:0] cmd_value;
  logic [IDX_W-1:0]        rd_slot;
  logic [CNT_W-1:0]        scan_cnt;

  logic                    accept;
  logic                    out_free;
  logic [LIM_W-1:0]        cap_ext;
  logic [LIM_W-1:0]        limit;
  logic                    is_empty;
  logic                    is_full;
  logic                    hit;
  logic                    last;
  logic                    finish;
  logic                    done;
  logic                    scan_step;

  logic [STAT_W-1:0]            status_next;
  logic signed [DATA_WIDTH-1:0] popped_value_next;
  logic                         found_flag_next;

  logic                    ram_we;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_rdata;

  // Handshake
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Occupancy checks against the clamped capacity
  assign cap_ext  = LIM_W'(capacity);
  assign limit    = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
  assign is_empty = (entry_count == '0);
  assign is_full  = (LIM_W'(entry_count) >= limit);

  // Search compare on the entry currently in the read register
  assign hit  = (ram_rdata == cmd_value);
  assign last = (scan_cnt == entry_count - 1'b1);

  // Decide whether the current request can finish this cycle
  always_comb begin
    case (cmd_op)
      OP_SEARCH: finish = is_empty || hit || last;
      default:   finish = 1'b1;
    endcase
  end

  // Form the result of the current request
  always_comb begin
    status_next       = STAT_DONE;
    popped_value_next = '0;
    found_flag_next   = 1'b0;
    case (cmd_op)
      OP_PUSH: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          popped_value_next = ram_rdata;
        end
      end
      OP_SEARCH: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          found_flag_next = hit;
        end
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  assign done      = (state == S_EXEC) && finish && out_free;
  assign scan_step = (state == S_EXEC) && (cmd_op == OP_SEARCH) && !finish;

  // Store accesses: reads and writes never target the same cycle, since
  // writes happen only when a push finishes and reads start no earlier than
  // the next accepted request
  assign ram_re    = accept || scan_step;
  assign ram_raddr = (state == S_IDLE) ? head_index : rd_slot;
  assign ram_we    = done && (cmd_op == OP_PUSH) && !is_full;

  fqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_index),
    .wdata (cmd_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, queue pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity    <= CAP_W'(CAP_RESET);
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Capture configuration
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end

      // Load a finished result, else drop a result once taken
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_op    <= opcode;
            cmd_value <= value;
            scan_cnt  <= '0;
            rd_slot   <= next_slot(head_index);
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          // Advance the search walk
          if (scan_step) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_slot  <= next_slot(rd_slot);
          end
          // Finish: update pointers and load the result
          if (done) begin
            state        <= S_IDLE;
            status       <= status_next;
            popped_value <= popped_value_next;
            found_flag   <= found_flag_next;
            case (cmd_op)
              OP_PUSH: begin
                if (!is_full) begin
                  tail_index  <= next_slot(tail_index);
                  entry_count <= entry_count + 1'b1;
                end
              end
              OP_POP: begin
                if (!is_empty) begin
                  head_index  <= next_slot(head_index);
                  entry_count <= entry_count - 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/fqs_ram.sv]
// ----------------------------------------------------------------------------
// fqs_ram
// Generic single-write, single-read synchronous RAM. Read data is registered
// and holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
